/* rtl/core/sgrf_pkg.sv */
// ----------------------------------------------------------------------------
// sgrf_pkg - shared types and codes for the stereo gain ring FIFO
// Item layouts of the input and result channels, operation and register codes.
// ----------------------------------------------------------------------------
package sgrf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FILL_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CMD_Q_DEPTH = 4;

    // operation codes; the last three are reserved and ignored
    typedef enum logic [2:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_TICK     = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4,
        OP_UNUSED_5 = 3'd5,
        OP_UNUSED_6 = 3'd6,
        OP_UNUSED_7 = 3'd7
    } op_t;

    // register indexes of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN       = 2'd0,
        REG_PAUSED     = 2'd1,
        REG_HOLD_TICKS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]                 operation;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic [6:0]                 block_len;
    } in_item_t;

    typedef struct packed {
        logic                       push_accepted;
        logic                       pop_granted;
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last;
        logic [FILL_W-1:0]          fill_count;
    } out_item_t;

endpackage

/* rtl/core/sgrf_front.sv */
// ----------------------------------------------------------------------------
// sgrf_front - item decode, gain, FIFO bookkeeping
// Accepts items, scales and writes pushes, grants or refuses pops and
// hands one command per result-producing item to the back end.
// ----------------------------------------------------------------------------
module sgrf_front #(
    parameter  int DEPTH     = 1024,
    parameter  int MAX_BLOCK = 64,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int BW        = $clog2(MAX_BLOCK + 1),
    localparam int CMD_W     = 2 + CW + BW + AW,
    localparam int WR_W      = 1 + AW + 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sgrf_pkg::in_item_t              s_data,
    input  logic                            cfg_we,
    input  logic [sgrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            q_full,
    output logic                            q_wr_en,
    output logic [CMD_W-1:0]                q_wr_data,
    output logic [WR_W-1:0]                 wr_port,
    input  logic                            pop_done
);
    import sgrf_pkg::*;

    localparam logic [7:0]  GAIN_RESET = 8'd64;
    localparam logic [15:0] HOLD_RESET = 16'd1000;

    localparam int CMP_W = (CW > 7) ? CW : 7;
    localparam int OW    = $clog2(CMD_Q_DEPTH + 2);

    typedef struct packed {
        logic          stream;
        logic          acc;
        logic [CW-1:0] fill;
        logic [BW-1:0] n;
        logic [AW-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [31:0]   data;
    } wr_t;

    // floor shift by 6 then clamp to 16 bits
    function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [24:0] p);
        logic signed [18:0] q;
        logic [SAMPLE_W-1:0] r;
        q = p[24:6];
        if (q > 19'sd32767) begin
            r = 16'h7FFF;
        end else if (q < -19'sd32768) begin
            r = 16'h8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    logic [7:0]    gain_reg, gain_next;
    logic          paused_reg, paused_next;
    logic [15:0]   hold_ticks_reg, hold_ticks_next;
    logic [15:0]   hold_left_reg, hold_left_next;
    logic          running_reg, running_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [OW-1:0] outst_reg, outst_next;

    logic          is_push, is_pop, is_tick, is_start, is_stop;
    logic          enq_op, mod_op, accept, fifo_full, grant;
    logic [CMP_W-1:0] n_ext, cnt_ext;
    logic [AW:0]   rsum;
    logic signed [24:0] prod_l, prod_r;
    cmd_t          cmd;
    wr_t           wr;

    assign is_push  = (s_data.operation == OP_PUSH);
    assign is_pop   = (s_data.operation == OP_POP);
    assign is_tick  = (s_data.operation == OP_TICK);
    assign is_start = (s_data.operation == OP_START);
    assign is_stop  = (s_data.operation == OP_STOP);

    assign enq_op = is_push || is_pop;
    assign mod_op = is_push || is_start || is_stop;

    // writes and flushes wait until granted pops have read their frames
    assign s_ready = !(enq_op && q_full) && !(mod_op && (outst_reg != '0));
    assign accept  = s_valid && s_ready;

    assign fifo_full = (count_reg == CW'(DEPTH));
    assign n_ext     = CMP_W'(s_data.block_len);
    assign cnt_ext   = CMP_W'(count_reg);
    assign grant     = (n_ext != '0) && (n_ext <= CMP_W'(MAX_BLOCK)) &&
                       (cnt_ext >= n_ext) && (hold_left_reg == '0) && !paused_reg;

    assign prod_l = s_data.left_in  * $signed({1'b0, gain_reg});
    assign prod_r = s_data.right_in * $signed({1'b0, gain_reg});

    assign rsum = {1'b0, ridx_reg} + (AW + 1)'(s_data.block_len);

    always_comb begin
        gain_next       = gain_reg;
        paused_next     = paused_reg;
        hold_ticks_next = hold_ticks_reg;
        hold_left_next  = hold_left_reg;
        running_next    = running_reg;
        widx_next       = widx_reg;
        ridx_next       = ridx_reg;
        count_next      = count_reg;
        wr.en           = 1'b0;
        wr.addr         = widx_reg;
        wr.data         = {sat16(prod_l), sat16(prod_r)};

        if (accept) begin
            if (is_push && !fifo_full) begin
                wr.en      = 1'b1;
                widx_next  = (widx_reg == AW'(DEPTH - 1)) ? '0 : widx_reg + AW'(1);
                count_next = count_reg + CW'(1);
            end else if (is_pop && grant) begin
                ridx_next  = (rsum >= (AW + 1)'(DEPTH)) ? AW'(rsum - (AW + 1)'(DEPTH))
                                                        : AW'(rsum);
                count_next = count_reg - CW'(s_data.block_len);
            end else if (is_tick) begin
                if (hold_left_reg != '0) begin
                    hold_left_next = hold_left_reg - 16'd1;
                end
            end else if (is_start) begin
                widx_next      = '0;
                ridx_next      = '0;
                count_next     = '0;
                hold_left_next = hold_ticks_reg;
                paused_next    = 1'b0;
                running_next   = 1'b1;
            end else if (is_stop) begin
                widx_next    = '0;
                ridx_next    = '0;
                count_next   = '0;
                running_next = 1'b0;
            end
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_GAIN:       gain_next       = cfg_wdata[7:0];
                REG_PAUSED:     paused_next     = cfg_wdata[0];
                REG_HOLD_TICKS: hold_ticks_next = cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        cmd.stream = is_pop && grant;
        cmd.acc    = is_push && !fifo_full;
        cmd.fill   = is_push ? count_next : count_reg;
        cmd.n      = BW'(s_data.block_len);
        cmd.addr   = ridx_reg;
    end

    assign q_wr_en   = accept && enq_op;
    assign q_wr_data = cmd;
    assign wr_port   = wr;

    assign outst_next = outst_reg + OW'(q_wr_en && cmd.stream) - OW'(pop_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= GAIN_RESET;
            paused_reg     <= 1'b0;
            hold_ticks_reg <= HOLD_RESET;
            hold_left_reg  <= '0;
            running_reg    <= 1'b0;
            widx_reg       <= '0;
            ridx_reg       <= '0;
            count_reg      <= '0;
            outst_reg      <= '0;
        end else begin
            gain_reg       <= gain_next;
            paused_reg     <= paused_next;
            hold_ticks_reg <= hold_ticks_next;
            hold_left_reg  <= hold_left_next;
            running_reg    <= running_next;
            widx_reg       <= widx_next;
            ridx_reg       <= ridx_next;
            count_reg      <= count_next;
            outst_reg      <= outst_next;
        end
    end

    // a finished pop must have been counted as outstanding
    a_pop_done_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_done |-> (outst_reg != '0))
        else $error("pop completion with no outstanding pop");

endmodule

/* rtl/core/sgrf_cmd_q.sv */
// ----------------------------------------------------------------------------
// sgrf_cmd_q - command queue between front and back end
// Small register FIFO, head visible combinationally.
// ----------------------------------------------------------------------------
module sgrf_cmd_q #(
    parameter  int WIDTH = 32,
    parameter  int QD    = 4,
    localparam int PW    = (QD > 1) ? $clog2(QD) : 1,
    localparam int NW    = $clog2(QD + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] slot_reg [QD];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [NW-1:0]    num_reg;

    assign full    = (num_reg == NW'(QD));
    assign empty   = (num_reg == '0);
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            num_reg  <= '0;
        end else begin
            if (wr_en) begin
                wptr_reg <= (wptr_reg == PW'(QD - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (rd_en) begin
                rptr_reg <= (rptr_reg == PW'(QD - 1)) ? '0 : rptr_reg + PW'(1);
            end
            num_reg <= num_reg + NW'(wr_en) - NW'(rd_en);
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full)
        else $error("command queue written while full");

    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty)
        else $error("command queue read while empty");

endmodule

/* rtl/core/sgrf_back.sv */
// ----------------------------------------------------------------------------
// sgrf_back - frame store and result streaming
// Holds the sample memory, runs queued commands and buffers results.
// ----------------------------------------------------------------------------
module sgrf_back #(
    parameter  int DEPTH     = 1024,
    parameter  int MAX_BLOCK = 64,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int BW        = $clog2(MAX_BLOCK + 1),
    localparam int CMD_W     = 2 + CW + BW + AW,
    localparam int WR_W      = 1 + AW + 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_rd_en,
    input  logic [CMD_W-1:0]    q_rd_data,
    input  logic [WR_W-1:0]     wr_port,
    output logic                pop_done,
    output logic                m_valid,
    input  logic                m_ready,
    output sgrf_pkg::out_item_t m_data
);
    import sgrf_pkg::*;

    typedef struct packed {
        logic          stream;
        logic          acc;
        logic [CW-1:0] fill;
        logic [BW-1:0] n;
        logic [AW-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [31:0]   data;
    } wr_t;

    cmd_t cmd;
    wr_t  wr;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   mem_q_reg;

    logic          busy_reg;
    logic [BW-1:0] rem_reg;
    logic [AW-1:0] raddr_reg;
    logic [CW-1:0] fill_reg;

    logic          s1_valid_reg;
    logic          s1_acc_reg, s1_grant_reg, s1_last_reg;
    logic [CW-1:0] s1_fill_reg;

    out_item_t     obuf_reg [2];
    logic          owptr_reg, orptr_reg;
    logic [1:0]    occ_reg;

    logic          take, can_issue, rd_issue, deq;
    out_item_t     s1_item;

    assign cmd = q_rd_data;
    assign wr  = wr_port;

    assign take      = m_valid && m_ready;
    // room for the result in flight plus the one issued now
    assign can_issue = (3'(occ_reg) + 3'(s1_valid_reg) - 3'(take)) < 3'd2;
    assign rd_issue  = busy_reg && can_issue;
    assign deq       = !busy_reg && q_valid && can_issue;
    assign q_rd_en   = deq;
    assign pop_done  = rd_issue && (rem_reg == BW'(1));

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_issue) begin
            mem_q_reg <= mem[raddr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= rd_issue || (deq && !cmd.stream);
            if (deq && cmd.stream) begin
                busy_reg <= 1'b1;
            end else if (pop_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (deq) begin
            rem_reg      <= cmd.n;
            raddr_reg    <= cmd.addr;
            fill_reg     <= cmd.fill;
            s1_acc_reg   <= cmd.acc;
            s1_grant_reg <= 1'b0;
            s1_last_reg  <= 1'b1;
            s1_fill_reg  <= cmd.fill;
        end else if (rd_issue) begin
            rem_reg      <= rem_reg - BW'(1);
            raddr_reg    <= (raddr_reg == AW'(DEPTH - 1)) ? '0 : raddr_reg + AW'(1);
            fill_reg     <= fill_reg - CW'(1);
            s1_acc_reg   <= 1'b0;
            s1_grant_reg <= 1'b1;
            s1_last_reg  <= (rem_reg == BW'(1));
            s1_fill_reg  <= fill_reg - CW'(1);
        end
    end

    always_comb begin
        s1_item.push_accepted = s1_acc_reg;
        s1_item.pop_granted   = s1_grant_reg;
        s1_item.left_out      = s1_grant_reg ? mem_q_reg[31:16] : '0;
        s1_item.right_out     = s1_grant_reg ? mem_q_reg[15:0] : '0;
        s1_item.last          = s1_last_reg;
        s1_item.fill_count    = FILL_W'(s1_fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            obuf_reg[owptr_reg] <= s1_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owptr_reg <= 1'b0;
            orptr_reg <= 1'b0;
            occ_reg   <= '0;
        end else begin
            if (s1_valid_reg) begin
                owptr_reg <= !owptr_reg;
            end
            if (take) begin
                orptr_reg <= !orptr_reg;
            end
            occ_reg <= occ_reg + 2'(s1_valid_reg) - 2'(take);
        end
    end

    assign m_valid = (occ_reg != '0);
    assign m_data  = obuf_reg[orptr_reg];

    a_obuf_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (occ_reg == 2'd2)) |-> m_ready)
        else $error("result buffer overflow");

    a_busy_has_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg != '0))
        else $error("streaming with no frames left");

endmodule

/* rtl/core/stereo_gain_ring_fifo.sv */
// ----------------------------------------------------------------------------
// stereo_gain_ring_fifo - stereo sample ring FIFO with input gain
// Front end for decode and bookkeeping, command queue, back end for the
// frame store and result stream.
// ----------------------------------------------------------------------------
// Items enter at up to one per cycle. A push scales both samples by the F2.6
// gain and writes the frame at once; it yields one result. A pop of N frames
// yields N results, one per cycle while the receiver keeps up, after the back
// end takes the command; frame store reads are registered. A pop that cannot
// be granted yields a single result. Tick, start and stop yield nothing. Up
// to four result-producing items queue between the two ends, so input keeps
// flowing while results stall. Push, start and stop wait while a granted pop
// still has frames to read, so a write never lands on a frame in flight. The
// frame store needs no clearing after reset: only written frames are read.
module stereo_gain_ring_fifo #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BLOCK = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sgrf_pkg::in_item_t              s_data,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output sgrf_pkg::out_item_t             m_data,
    // register writes: 0 gain, 1 paused, 2 hold_ticks
    input  logic                            cfg_we,
    input  logic [sgrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgrf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sgrf_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int BW    = $clog2(MAX_BLOCK + 1);
    localparam int CMD_W = 2 + CW + BW + AW;
    localparam int WR_W  = 1 + AW + 32;

    // command path front -> queue -> back
    logic             q_wr_en, q_rd_en, q_full, q_empty;
    logic [CMD_W-1:0] q_wr_data, q_rd_data;

    // frame store write port, driven by the front end
    logic [WR_W-1:0]  wr_port;

    // back end has issued the last read of a granted pop
    logic             pop_done;

    sgrf_front #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .wr_port   (wr_port),
        .pop_done  (pop_done)
    );

    sgrf_cmd_q #(
        .WIDTH   (CMD_W),
        .QD      (CMD_Q_DEPTH)
    ) u_cmd_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    sgrf_back #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (!q_empty),
        .q_rd_en   (q_rd_en),
        .q_rd_data (q_rd_data),
        .wr_port   (wr_port),
        .pop_done  (pop_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for stereo_gain_ring_fifo
// Drives push, pop, tick, start and stop items plus register writes. Every
// item accepted at the input is run through a behavioral copy of the gain
// stage and ring store. The frames, acks and fill counts that copy predicts
// are queued and compared in order against the result stream. A directed
// table comes first, then random phases that cover empty stores, maximum-size
// blocks, long receiver stalls and writes to each register, extremes included.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgrf_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int MAX_BLOCK      = 64;
    localparam int QUIET_CYCLES   = 8;      // drain time for items with no result
    localparam int RX_HOLD_CYCLES = 300;    // long receiver stall
    localparam int ERR_PRINT_MAX  = 100;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        in_item_t   item;
        bit         typed;      // want holds the one result, typed in by hand
        out_item_t  want;
        reg_idx_t   reg_idx;
        logic [15:0] reg_val;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    stereo_gain_ring_fifo #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the FIFO: registers, ring store and bookkeeping
    // ------------------------------------------------------------------------
    logic [31:0] mdl_store [DEPTH];     // left in the high half
    logic [9:0]  mdl_wr;
    logic [9:0]  mdl_rd;
    logic [10:0] mdl_count;
    logic [15:0] mdl_hold;
    logic        mdl_running;
    logic [7:0]  mdl_gain;
    logic        mdl_paused;
    logic [15:0] mdl_hold_ticks;

    out_item_t   due_results[$];        // results still owed by the DUT
    int          err_count;

    // side band that travels with the item on s_data
    bit          row_typed;
    out_item_t   row_want;

    // receiver control, written by the sender only right after a rising edge
    int          rx_hold_reqs;
    bit          rx_steady;

    function automatic in_item_t mk_item(op_t op, logic [15:0] l, logic [15:0] r,
                                         logic [6:0] len);
        in_item_t it;
        it.operation = op;
        it.left_in   = l;
        it.right_in  = r;
        it.block_len = len;
        return it;
    endfunction

    function automatic out_item_t mk_res(logic acc, logic grant, logic [15:0] l,
                                         logic [15:0] r, logic last, logic [10:0] fill);
        out_item_t res;
        res.push_accepted = acc;
        res.pop_granted   = grant;
        res.left_out      = l;
        res.right_out     = r;
        res.last          = last;
        res.fill_count    = fill;
        return res;
    endfunction

    // F2.6 gain: multiply, floor shift by 6, clamp to 16 bits signed
    function automatic logic [15:0] apply_gain(logic signed [15:0] smp);
        int prod;
        int q;
        prod = int'(smp) * int'(mdl_gain);
        q    = prod >>> 6;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_GAIN:       mdl_gain       = val[7:0];
            REG_PAUSED:     mdl_paused     = val[0];
            REG_HOLD_TICKS: mdl_hold_ticks = val;
            default: ;
        endcase
    endfunction

    // Advances the FIFO copy by one item and queues the results it owes.
    function automatic void predict_results(in_item_t it, bit typed, out_item_t want);
        out_item_t   calc[$];
        logic [31:0] frame;
        int          n;
        logic        ok;
        case (it.operation)
            OP_PUSH: begin
                ok = (mdl_count < DEPTH);
                if (ok) begin
                    mdl_store[mdl_wr] = {apply_gain(it.left_in), apply_gain(it.right_in)};
                    mdl_wr    = mdl_wr + 1'b1;
                    mdl_count = mdl_count + 1'b1;
                end
                calc.push_back(mk_res(ok, 1'b0, '0, '0, 1'b1, mdl_count));
            end
            OP_POP: begin
                n = it.block_len;
                if (n == 0 || n > MAX_BLOCK || mdl_count < n || mdl_hold != 0 || mdl_paused) begin
                    calc.push_back(mk_res(1'b0, 1'b0, '0, '0, 1'b1, mdl_count));
                end else begin
                    for (int k = 0; k < n; k++) begin
                        frame     = mdl_store[mdl_rd];
                        mdl_rd    = mdl_rd + 1'b1;
                        mdl_count = mdl_count - 1'b1;
                        calc.push_back(mk_res(1'b0, 1'b1, frame[31:16], frame[15:0],
                                              k == n - 1, mdl_count));
                    end
                end
            end
            OP_TICK: begin
                if (mdl_hold != 0) mdl_hold = mdl_hold - 1'b1;
            end
            OP_START: begin
                mdl_wr      = '0;
                mdl_rd      = '0;
                mdl_count   = '0;
                mdl_hold    = mdl_hold_ticks;
                mdl_paused  = 1'b0;
                mdl_running = 1'b1;
            end
            OP_STOP: begin
                mdl_wr      = '0;
                mdl_rd      = '0;
                mdl_count   = '0;
                mdl_running = 1'b0;
            end
            default: ;  // unused codes are dropped
        endcase
        // hand-typed rows carry exactly one result
        if (typed) begin
            due_results.push_back(want);
        end else begin
            foreach (calc[i]) due_results.push_back(calc[i]);
        end
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (due_results.size() == 0) begin
            err_count++;
            if (err_count <= ERR_PRINT_MAX)
                $display("%0t: unexpected result acc=%0d grant=%0d l=%0d r=%0d last=%0d fill=%0d",
                         $time, got.push_accepted, got.pop_granted, got.left_out,
                         got.right_out, got.last, got.fill_count);
        end else begin
            want = due_results.pop_front();
            if (got !== want) begin
                err_count++;
                if (err_count <= ERR_PRINT_MAX)
                    $display({"%0t: result mismatch: expected acc=%0d grant=%0d l=%0d r=%0d",
                              " last=%0d fill=%0d, got acc=%0d grant=%0d l=%0d r=%0d",
                              " last=%0d fill=%0d"},
                             $time, want.push_accepted, want.pop_granted, want.left_out,
                             want.right_out, want.last, want.fill_count,
                             got.push_accepted, got.pop_granted, got.left_out,
                             got.right_out, got.last, got.fill_count);
            end
        end
    endfunction

    // Everything seen at a rising edge is handled in one process, so the
    // prediction of an item always lands before any result check of that edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) apply_reg_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready) predict_results(s_data, row_typed, row_want);
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, stall-free stretches, and one long hold-off
    // ------------------------------------------------------------------------
    int rx_hold_done;
    int rx_hold_left;

    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= 1'b0;
        end else if (rx_hold_reqs != rx_hold_done) begin
            rx_hold_done <= rx_hold_done + 1;
            rx_hold_left <= RX_HOLD_CYCLES - 1;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= rx_steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    // Called right after a falling edge; returns at the edge that takes the item.
    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        s_valid   <= 1'b1;
        s_data    <= it;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap(int n);
        @(negedge aclk) s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Stop offering, wait for every owed result, then let quiet items finish.
    // Returns right after a rising edge.
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Mostly well-formed traffic: ticks while the hold runs, pops sized to
    // what is stored; a slice of noise (bad lengths, unused codes, resets).
    function automatic in_item_t pick_item();
        in_item_t it;
        int       r;
        int       lim;
        it.operation = OP_PUSH;
        it.left_in   = 16'($urandom);
        it.right_in  = 16'($urandom);
        it.block_len = 7'($urandom);
        if ($urandom_range(0, 9) == 0) it.left_in  = pick_edge();
        if ($urandom_range(0, 9) == 0) it.right_in = pick_edge();
        r = $urandom_range(0, 99);
        if (mdl_hold != 0 && $urandom_range(0, 99) < 60) begin
            it.operation = OP_TICK;
        end else if (r < 45) begin
            it.operation = OP_PUSH;
        end else if (r < 80) begin
            it.operation = OP_POP;
            lim = (mdl_count > MAX_BLOCK) ? MAX_BLOCK : int'(mdl_count);
            if (lim == 0) lim = 1;
            it.block_len = 7'(($urandom_range(0, 9) == 0) ? lim : $urandom_range(1, lim));
        end else if (r < 87) begin
            it.operation = OP_TICK;
        end else if (r < 90) begin
            it.operation = OP_START;
        end else if (r < 92) begin
            it.operation = OP_STOP;
        end else if (r < 95) begin
            case ($urandom_range(0, 2))
                0:       it.operation = OP_UNUSED_5;
                1:       it.operation = OP_UNUSED_6;
                default: it.operation = OP_UNUSED_7;
            endcase
        end else begin
            it.operation = OP_POP;      // block_len left fully random
        end
        return it;
    endfunction

    task automatic run_random(int n, bit steady);
        for (int k = 0; k < n; k++) begin
            @(negedge aclk);
            send_item(pick_item(), 1'b0, '0);
            if (!steady && $urandom_range(0, 99) < 10) idle_gap($urandom_range(1, 6));
        end
    endtask

    // Settle, program all registers, optionally start the FIFO.
    task automatic new_phase(logic [7:0] g, logic p, logic [15:0] h, bit steady_rx,
                             bit do_start);
        settle();
        rx_steady = steady_rx;
        cfg_write(REG_GAIN, {8'h00, g});
        cfg_write(REG_PAUSED, {15'h0000, p});
        cfg_write(REG_HOLD_TICKS, h);
        if (do_start) begin
            @(negedge aclk);
            send_item(mk_item(OP_START, 16'($urandom), 16'($urandom), 7'($urandom)),
                      1'b0, '0);
        end
    endtask

    function automatic logic [7:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd64;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    stim_row_t dir_rows[$];

    function automatic stim_row_t row_item(in_item_t it, bit typed, out_item_t want);
        stim_row_t row;
        row.kind    = ROW_ITEM;
        row.item    = it;
        row.typed   = typed;
        row.want    = want;
        row.reg_idx = REG_GAIN;
        row.reg_val = '0;
        return row;
    endfunction

    function automatic stim_row_t row_cfg(reg_idx_t idx, logic [15:0] val);
        stim_row_t row;
        row         = row_item('0, 1'b0, '0);
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        rx_hold_reqs = 0;
        rx_hold_done = 0;
        rx_hold_left = 0;
        rx_steady    = 1'b1;
        err_count    = 0;

        // reset state of the copy; store contents are never read unwritten
        mdl_wr         = '0;
        mdl_rd         = '0;
        mdl_count      = '0;
        mdl_hold       = '0;
        mdl_running    = 1'b0;
        mdl_gain       = 8'd64;
        mdl_paused     = 1'b0;
        mdl_hold_ticks = 16'd1000;

        // Directed table. Hand-typed rows: acks, refusals and fill counts.
        // After reset the hold is zero, so pops work before any start.
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd1), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd0)));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'h7FFF, 16'h8000, 7'd0), 1'b1,
                                    mk_res(1'b1, 1'b0, '0, '0, 1'b1, 11'd1)));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'hFFFF, 16'h0001, 7'd127), 1'b1,
                                    mk_res(1'b1, 1'b0, '0, '0, 1'b1, 11'd2)));
        // zero length, one past the maximum, more than stored
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd0), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd2)));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'hFFFF, 16'hFFFF, 7'd65), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd2)));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd3), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd2)));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd2), 1'b0, '0));
        // unused codes must leave no trace
        dir_rows.push_back(row_item(mk_item(OP_UNUSED_5, 16'h5555, 16'hAAAA, 7'd1), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_UNUSED_6, 16'hAAAA, 16'h5555, 7'd64), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_UNUSED_7, 16'hFFFF, 16'hFFFF, 7'd127), 1'b0, '0));
        // tick with the hold already at zero keeps it there
        dir_rows.push_back(row_item(mk_item(OP_TICK, 16'h0000, 16'h0000, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'h1234, 16'h8001, 7'd0), 1'b1,
                                    mk_res(1'b1, 1'b0, '0, '0, 1'b1, 11'd1)));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd1), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'h0005, 16'hFFFB, 7'd0), 1'b1,
                                    mk_res(1'b1, 1'b0, '0, '0, 1'b1, 11'd1)));
        dir_rows.push_back(row_item(mk_item(OP_STOP, 16'h0000, 16'h0000, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd1), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd0)));
        // start arms the reset hold of 1000 ticks: pop refused
        dir_rows.push_back(row_item(mk_item(OP_START, 16'h0000, 16'h0000, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'd100, -16'sd100, 7'd0), 1'b1,
                                    mk_res(1'b1, 1'b0, '0, '0, 1'b1, 11'd1)));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd1), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd1)));
        dir_rows.push_back(row_item(mk_item(OP_TICK, 16'h0000, 16'h0000, 7'd0), 1'b0, '0));
        // maximum gain saturates both rails; rounding toward minus infinity
        dir_rows.push_back(row_cfg(REG_GAIN, 16'd255));
        dir_rows.push_back(row_cfg(REG_HOLD_TICKS, 16'd0));
        dir_rows.push_back(row_item(mk_item(OP_START, 16'h0000, 16'h0000, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'h7FFF, 16'h8000, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'd129, -16'sd129, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_cfg(REG_PAUSED, 16'd1));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd2), 1'b1,
                                    mk_res(1'b0, 1'b0, '0, '0, 1'b1, 11'd2)));
        dir_rows.push_back(row_cfg(REG_PAUSED, 16'd0));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd2), 1'b0, '0));
        // zero gain
        dir_rows.push_back(row_cfg(REG_GAIN, 16'd0));
        dir_rows.push_back(row_item(mk_item(OP_PUSH, 16'h8000, 16'h7FFF, 7'd0), 1'b0, '0));
        dir_rows.push_back(row_item(mk_item(OP_POP, 16'h0000, 16'h0000, 7'd1), 1'b0, '0));
        dir_rows.push_back(row_cfg(REG_GAIN, 16'd64));

        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                @(negedge aclk);
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // long stretch with no idling on either side
        new_phase(8'd64, 1'b0, 16'd2, 1'b1, 1'b1);
        run_random(80, 1'b1);

        // hold that never runs out: every pop refused
        new_phase(8'd255, 1'b0, 16'hFFFF, 1'b0, 1'b1);
        run_random(25, 1'b0);

        new_phase(8'd0, 1'b0, 16'd0, 1'b0, 1'b1);
        run_random(30, 1'b0);

        // paused without a start; a random start in the phase unpauses
        new_phase(8'($urandom), 1'b1, 16'($urandom_range(0, 3)), 1'b0, 1'b0);
        run_random(30, 1'b0);

        // receiver holds off while the sender keeps offering: input must stall
        settle();
        rx_hold_reqs = rx_hold_reqs + 1;
        new_phase(pick_gain(), 1'b0, 16'd0, 1'b0, 1'b1);
        run_random(60, 1'b1);

        // build up two maximum blocks, then drain them in maximum-size pops
        new_phase(pick_gain(), 1'b0, 16'd0, 1'b0, 1'b1);
        while (mdl_count < 2 * MAX_BLOCK) begin
            @(negedge aclk);
            send_item(mk_item(OP_PUSH, 16'($urandom), 16'($urandom), 7'($urandom)), 1'b0, '0);
            if ($urandom_range(0, 99) < 10) idle_gap($urandom_range(1, 4));
        end
        repeat (2) begin
            @(negedge aclk);
            send_item(mk_item(OP_POP, 16'($urandom), 16'($urandom), 7'(MAX_BLOCK)), 1'b0, '0);
        end

        repeat (3) begin
            new_phase(pick_gain(), $urandom_range(0, 4) == 0,
                      16'($urandom_range(0, 3)), 1'b0, $urandom_range(0, 9) < 7);
            run_random(20, 1'b0);
        end

        settle();
        if (err_count == 0 && due_results.size() == 0) begin
            $display("PASS stereo_gain_ring_fifo");
        end else begin
            $display("FAIL stereo_gain_ring_fifo");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("FAIL stereo_gain_ring_fifo");
        $finish;
    end

endmodule
